// File: sv/scse_pkg.sv
// ============================================================================
// scse_pkg
// Types and fixed-point constants shared by the Stumpff C/S evaluator.
// ============================================================================
`default_nettype none

package scse_pkg;

  // Internal unsigned Q.40 format
  localparam int unsigned IFRAC        = 40;
  localparam logic [63:0] ONE          = 64'h0000_0100_0000_0000;
  localparam logic [63:0] PI_Q         = 64'h0000_0324_3F6A_8885;
  localparam logic [63:0] TWO_PI_Q     = 64'h0000_0648_7ED5_110B;
  localparam logic [63:0] HYP_LIMIT    = 64'h0000_1000_0000_0000;
  localparam int unsigned OUT_FRAC     = 26;
  localparam logic [63:0] OUT_SCALE    = 64'h0000_0000_0400_0000;
  localparam logic [63:0] OUT_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned CLOSED_TERMS = 40;
  localparam int unsigned ROOT_TOP     = 50;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned N_W          = 7;

  // Operands of one floor(a*b/d) request
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
  } md_req_t;

endpackage

`default_nettype wire

// File: sv/scse_arg_if.sv
// ============================================================================
// scse_arg_if
// Argument channel: function select and signed fixed-point z.
// ============================================================================
`default_nettype none

interface scse_arg_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] z_arg;

  modport source (output valid, output mode, output z_arg, input ready);
  modport sink   (input valid, input mode, input z_arg, output ready);
endinterface

`default_nettype wire

// File: sv/scse_res_if.sv
// ============================================================================
// scse_res_if
// Result channel: unsigned Q6.26 value and saturation flag.
// ============================================================================
`default_nettype none

interface scse_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] func_value;
  logic        saturated;

  modport source (output valid, output func_value, output saturated, input ready);
  modport sink   (input valid, input func_value, input saturated, output ready);
endinterface

`default_nettype wire

// File: sv/stumpff_c_s_evaluator_core.sv
// ============================================================================
// stumpff_c_s_evaluator_core
// Stumpff C(z) / S(z) evaluator, series for |z| < 1, closed form otherwise.
// ============================================================================
// Operations: every step runs on one shared floor(a*b/d) unit (request,
//   start, multiply, range check, divide, handoff). |z| < 1 takes
//   SERIES_TERMS such operations. Otherwise a 51-bit square root, at most
//   one reduction subtract, 40 series terms and up to 3 more operations run.
// Throughput: one transaction at a time; a new argument is accepted the cycle
//   after the result is loaded, even while that result still waits.
// Reset: rst (synchronous, active high) returns the sequencer to idle and
//   drops any pending result.
// ============================================================================
`default_nettype none

module stumpff_c_s_evaluator_core
  import scse_pkg::*;
#(
  parameter int unsigned SERIES_TERMS  = 12,
  parameter int unsigned ARG_FRAC_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  scse_arg_if.sink   arg,
  scse_res_if.source res
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT_REQ, S_ROOT_WAIT, S_ROOT_END, S_REDUCE, S_X2_REQ, S_X2_WAIT,
    S_TERM_REQ, S_TERM_WAIT, S_POST, S_DEN_REQ, S_DEN_WAIT, S_DIV_REQ,
    S_DIV_WAIT, S_OUT
  } state_t;

  state_t           state;
  logic             mode_r;
  logic             neg;
  logic             series_r;
  logic [63:0]      w;
  logic [63:0]      r;
  logic [5:0]       root_bit;
  logic [63:0]      red;
  logic             flip;
  logic [63:0]      t;
  logic [63:0]      q_r;
  logic [63:0]      sum;
  logic [N_W-1:0]   n;
  logic             alt;
  logic             minus;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      num_r;
  logic [63:0]      den_r;
  logic [31:0]      val_r;
  logic             sat_r;
  logic             res_valid;
  logic [31:0]      res_value;
  logic             res_sat;

  logic             md_start;
  md_req_t          md_req;
  logic             md_done;
  logic [63:0]      md_q;

  // Combinational helpers
  logic [31:0]      mag;
  logic [63:0]      root_c;
  logic [2*N_W-1:0] term_k;
  logic [63:0]      term_div;
  logic [63:0]      sin_v;
  logic [63:0]      num_c;

  always_comb begin
    mag      = arg.z_arg[31] ? (32'd0 - arg.z_arg) : arg.z_arg;
    root_c   = r | (64'd1 << root_bit);
    term_k   = (2*N_W)'(n) * (2*N_W)'(n + N_W'(1));
    term_div = 64'(term_k) << IFRAC;
    sin_v    = flip ? (64'd0 - sum) : sum;
    if (!neg) begin
      num_c = mode_r ? (r - sin_v) : (ONE - sum);
      if (num_c[63]) begin
        num_c = '0;
      end
    end else begin
      num_c = mode_r ? (sum - r) : (sum - ONE);
    end
  end

  assign arg.ready      = (state == S_IDLE);
  assign res.valid      = res_valid;
  assign res.func_value = res_value;
  assign res.saturated  = res_sat;

  scse_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      md_start  <= 1'b0;
    end else begin
      // Pulse the shared unit from every request state
      md_start <= (state == S_ROOT_REQ) || (state == S_X2_REQ) ||
                  (state == S_TERM_REQ) || (state == S_DEN_REQ) ||
                  (state == S_DIV_REQ);
      // Drop the result once the sink takes it, unless a new one replaces it
      if (res_valid && res.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (arg.valid) begin
            mode_r <= arg.mode;
            neg    <= arg.z_arg[31];
            w      <= 64'(mag) << (IFRAC - ARG_FRAC_BITS);
            if ((mag >> ARG_FRAC_BITS) == 32'd0) begin
              // Power series from 1/2 or 1/6, alternating for z >= 0
              series_r <= 1'b1;
              t        <= arg.mode ? ONE / 6 : ONE / 2;
              sum      <= arg.mode ? ONE / 6 : ONE / 2;
              q_r      <= 64'(mag) << (IFRAC - ARG_FRAC_BITS);
              n        <= arg.mode ? N_W'(4) : N_W'(3);
              alt      <= !arg.z_arg[31];
              minus    <= !arg.z_arg[31];
              cnt      <= CNT_W'(SERIES_TERMS);
              state    <= S_TERM_REQ;
            end else begin
              series_r <= 1'b0;
              r        <= '0;
              root_bit <= 6'(ROOT_TOP);
              state    <= S_ROOT_REQ;
            end
          end
        end
        // Square root, one bit per pass, high bit first
        S_ROOT_REQ: begin
          md_req   <= '{a: root_c, b: root_c, d: ONE};
          state    <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (md_done) begin
            if (md_q <= w) begin
              r <= root_c;
            end
            if (root_bit == 6'd0) begin
              state <= S_ROOT_END;
            end else begin
              root_bit <= root_bit - 6'd1;
              state    <= S_ROOT_REQ;
            end
          end
        end
        S_ROOT_END: begin
          if (neg && r >= HYP_LIMIT) begin
            // Both hyperbolic forms exceed the output range here
            val_r <= '1;
            sat_r <= 1'b1;
            state <= S_OUT;
          end else if (!neg) begin
            red   <= r;
            state <= S_REDUCE;
          end else begin
            t     <= mode_r ? r : ONE;
            sum   <= mode_r ? r : ONE;
            q_r   <= w;
            n     <= mode_r ? N_W'(2) : N_W'(1);
            alt   <= 1'b0;
            minus <= 1'b0;
            cnt   <= CNT_W'(CLOSED_TERMS);
            state <= S_TERM_REQ;
          end
        end
        // Reduce r modulo 2pi, then fold into [0, pi]
        S_REDUCE: begin
          if (red >= TWO_PI_Q) begin
            red <= red - TWO_PI_Q;
          end else begin
            flip  <= red > PI_Q;
            t     <= (red > PI_Q) ? TWO_PI_Q - red : red;
            state <= S_X2_REQ;
          end
        end
        S_X2_REQ: begin
          md_req   <= '{a: t, b: t, d: ONE};
          state    <= S_X2_WAIT;
        end
        S_X2_WAIT: begin
          if (md_done) begin
            q_r   <= md_q;
            t     <= mode_r ? t : ONE;
            sum   <= mode_r ? t : ONE;
            n     <= mode_r ? N_W'(2) : N_W'(1);
            alt   <= 1'b1;
            minus <= 1'b1;
            cnt   <= CNT_W'(CLOSED_TERMS);
            state <= S_TERM_REQ;
          end
        end
        // Next term: previous * q / (n(n+1)), n advances by 2
        S_TERM_REQ: begin
          md_req   <= '{a: t, b: q_r, d: term_div};
          state    <= S_TERM_WAIT;
        end
        S_TERM_WAIT: begin
          if (md_done) begin
            t   <= md_q;
            n   <= n + N_W'(2);
            sum <= minus ? sum - md_q : sum + md_q;
            if (alt) begin
              minus <= !minus;
            end
            if (cnt == CNT_W'(1)) begin
              state <= S_POST;
            end else begin
              cnt   <= cnt - CNT_W'(1);
              state <= S_TERM_REQ;
            end
          end
        end
        S_POST: begin
          if (series_r) begin
            val_r <= sum[63] ? 32'd0 : sum[IFRAC-OUT_FRAC+31:IFRAC-OUT_FRAC];
            sat_r <= 1'b0;
            state <= S_OUT;
          end else begin
            num_r <= num_c;
            den_r <= w;
            state <= mode_r ? S_DEN_REQ : S_DIV_REQ;
          end
        end
        // r^3 = w * r for the S forms
        S_DEN_REQ: begin
          md_req   <= '{a: w, b: r, d: ONE};
          state    <= S_DEN_WAIT;
        end
        S_DEN_WAIT: begin
          if (md_done) begin
            den_r <= md_q;
            state <= S_DIV_REQ;
          end
        end
        S_DIV_REQ: begin
          md_req   <= '{a: num_r, b: OUT_SCALE, d: den_r};
          state    <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (md_done) begin
            if (md_q > OUT_MAX) begin
              val_r <= '1;
              sat_r <= 1'b1;
            end else begin
              val_r <= md_q[31:0];
              sat_r <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        // Hold until the output register is free
        S_OUT: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_value <= val_r;
            res_sat   <= sat_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/scse_muldiv.sv
// ============================================================================
// scse_muldiv
// Shared unit: q = floor(a*b/d) over a 128-bit product, all ones when d is
// zero or the quotient overflows. Four 32x32 partial products, then a
// restoring divide at one quotient bit per cycle.
// ============================================================================
`default_nettype none

module scse_muldiv
  import scse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire md_req_t     req,
  output logic             done,
  output logic [63:0]      q
);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_CHK, MD_DIV} md_state_t;

  md_state_t    state;
  logic [63:0]  a;
  logic [63:0]  b;
  logic [63:0]  d;
  logic [127:0] acc;
  logic [1:0]   step;
  logic [5:0]   bit_cnt;
  logic [63:0]  rem;

  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] acc_next;
  logic [63:0]  rem_sh;
  logic         take;

  always_comb begin
    a_part   = step[1] ? a[63:32] : a[31:0];
    b_part   = step[0] ? b[63:32] : b[31:0];
    pp       = 64'(a_part) * 64'(b_part);
    pp_sh    = {step[1] & step[0], step[1] ^ step[0], 5'b0};
    acc_next = acc + ({64'd0, pp} << pp_sh);
    rem_sh   = {rem[62:0], acc[63]};
    take     = rem[63] || (rem_sh >= d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      // Flag the cycle the quotient is final, either early or after the divide
      done <= ((state == MD_CHK) && (d == 64'd0 || acc[127:64] >= d)) ||
              ((state == MD_DIV) && (bit_cnt == 6'd0));
      case (state)
        MD_IDLE: begin
          if (start) begin
            a     <= req.a;
            b     <= req.b;
            d     <= req.d;
            acc   <= '0;
            step  <= 2'd0;
            state <= MD_MUL;
          end
        end
        MD_MUL: begin
          acc  <= acc_next;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= MD_CHK;
          end
        end
        MD_CHK: begin
          // Zero divisor, or quotient would not fit in 64 bits: return all ones
          if (d == 64'd0 || acc[127:64] >= d) begin
            q     <= '1;
            state <= MD_IDLE;
          end else begin
            rem     <= acc[127:64];
            bit_cnt <= 6'd63;
            q       <= '0;
            state   <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem            <= take ? rem_sh - d : rem_sh;
          acc[63:0]      <= {acc[62:0], 1'b0};
          q              <= {q[62:0], take};
          bit_cnt        <= bit_cnt - 6'd1;
          if (bit_cnt == 6'd0) begin
            state <= MD_IDLE;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/scse_checker.sv
// ============================================================================
// scse_checker
// Port-level checks for the Stumpff evaluator, bound to the top level.
// ============================================================================
`default_nettype none

module scse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        arg_valid,
  input wire logic        arg_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] func_value,
  input wire logic        saturated
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(func_value) && $stable(saturated))
    else $error("result changed while stalled");

  // Saturation always shows the all-ones code
  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |-> func_value == 32'hFFFF_FFFF)
    else $error("saturated result without all-ones value");

  // One transaction at a time: busy after accepting
  a_busy: assert property (@(posedge clk) disable iff (rst)
    arg_valid && arg_ready |=> !arg_ready)
    else $error("argument accepted while busy");

  // Reset drops any pending result
  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind stumpff_c_s_evaluator_core scse_checker u_scse_checker (
  .clk        (clk),
  .rst        (rst),
  .arg_valid  (arg.valid),
  .arg_ready  (arg.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .func_value (res.func_value),
  .saturated  (res.saturated)
);

`default_nettype wire

// File: verif/stumpff_scoreboard.sv
// ============================================================================
// stumpff_scoreboard
// Predicts the Stumpff C(z) or S(z) of each accepted argument and checks the
// results against the oldest waiting prediction.
// ============================================================================
`default_nettype none

class stumpff_scoreboard;
  localparam int unsigned ARG_FRAC = 24;
  localparam int unsigned SER_TERMS = 12;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } func_result_t;

  func_result_t pending_results[$];
  int unsigned  error_count;
  int unsigned  checked_count;
  int unsigned  series_count;
  int unsigned  closed_count;
  int unsigned  sat_count;

  function new();
    error_count   = 0;
    checked_count = 0;
    series_count  = 0;
    closed_count  = 0;
    sat_count     = 0;
  endfunction

  // floor(a*b/d), all ones on a zero divisor or a quotient wider than 64 bits
  function logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, b};
    if (d == 64'd0 || prod[127:64] >= d) return '1;
    quo = prod / {64'd0, d};
    return quo[63:0];
  endfunction

  function logic [63:0] taylor_sum(logic [63:0] t, logic [63:0] q, int unsigned n,
                                   bit alt, int unsigned count);
    logic [63:0] sum;
    bit          minus;
    sum   = t;
    minus = alt;
    for (int unsigned i = 0; i < count; i++) begin
      t = mul_div(t, q, scse_pkg::ONE * 64'(n * (n + 1)));
      n += 2;
      sum = minus ? sum - t : sum + t;
      if (alt) minus = !minus;
    end
    return sum;
  endfunction

  function logic [63:0] isqrt_q40(logic [63:0] w);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = scse_pkg::ROOT_TOP; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (mul_div(c, c, scse_pkg::ONE) <= w) r = c;
    end
    return r;
  endfunction

  function func_result_t stumpff_value(logic mode, logic [31:0] raw);
    func_result_t res;
    bit           neg;
    bit           flip;
    bit           sat;
    logic [31:0]  mag32;
    logic [63:0]  mag, w, s, r, red, x, x2, sv, num, den, val;
    neg   = raw[31];
    mag32 = neg ? (32'd0 - raw) : raw;
    mag   = {32'd0, mag32};
    w     = mag << (scse_pkg::IFRAC - ARG_FRAC);
    val   = '0;
    sat   = 1'b0;
    if (mag < (64'd1 << ARG_FRAC)) begin
      series_count++;
      s = taylor_sum(mode ? scse_pkg::ONE / 6 : scse_pkg::ONE / 2, w, mode ? 4 : 3,
                     !neg, SER_TERMS);
      val = s[63] ? 64'd0 : (s >> (scse_pkg::IFRAC - scse_pkg::OUT_FRAC));
    end else begin
      closed_count++;
      r = isqrt_q40(w);
      if (neg && r >= scse_pkg::HYP_LIMIT) begin
        sat = 1'b1;
      end else begin
        if (!neg) begin
          red  = r % scse_pkg::TWO_PI_Q;
          flip = red > scse_pkg::PI_Q;
          x    = flip ? scse_pkg::TWO_PI_Q - red : red;
          x2   = mul_div(x, x, scse_pkg::ONE);
          if (mode == 1'b0) begin
            num = scse_pkg::ONE - taylor_sum(scse_pkg::ONE, x2, 1, 1'b1,
                                             scse_pkg::CLOSED_TERMS);
            den = w;
          end else begin
            sv = taylor_sum(x, x2, 2, 1'b1, scse_pkg::CLOSED_TERMS);
            if (flip) sv = 64'd0 - sv;
            num = r - sv;
            den = mul_div(w, r, scse_pkg::ONE);
          end
          if (num[63]) num = '0;
        end else if (mode == 1'b0) begin
          num = taylor_sum(scse_pkg::ONE, w, 1, 1'b0, scse_pkg::CLOSED_TERMS)
                - scse_pkg::ONE;
          den = w;
        end else begin
          num = taylor_sum(r, w, 2, 1'b0, scse_pkg::CLOSED_TERMS) - r;
          den = mul_div(w, r, scse_pkg::ONE);
        end
        val = mul_div(num, scse_pkg::OUT_SCALE, den);
        if (val > scse_pkg::OUT_MAX) sat = 1'b1;
      end
    end
    if (sat) begin
      val = scse_pkg::OUT_MAX;
      sat_count++;
    end
    res.value = val[31:0];
    res.sat   = sat;
    return res;
  endfunction

  function void note_argument(logic mode, logic [31:0] z_arg);
    pending_results.push_back(stumpff_value(mode, z_arg));
  endfunction

  task report(string what);
    error_count++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  task check_result(logic [31:0] func_value, logic saturated);
    func_result_t exp_res;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result value=%h sat=%b", func_value, saturated));
      return;
    end
    exp_res = pending_results.pop_front();
    checked_count++;
    if (func_value !== exp_res.value)
      report($sformatf("func_value %h, expected %h", func_value, exp_res.value));
    if (saturated !== exp_res.sat)
      report($sformatf("saturated %b, expected %b", saturated, exp_res.sat));
  endtask
endclass

`default_nettype wire

// File: verif/tb_stumpff_c_s_evaluator_core.sv
// ============================================================================
// tb_stumpff_c_s_evaluator_core
// Self-checking bench for the Stumpff C/S evaluator: directed corner
// arguments, then random arguments under varying valid/ready idling and a
// long result-side hold, each result checked against a bit-exact predictor.
// ============================================================================
`default_nettype none

module tb_stumpff_c_s_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scse_arg_if arg ();
  scse_res_if res ();

  stumpff_c_s_evaluator_core dut (
    .clk (clk),
    .rst (rst),
    .arg (arg.sink),
    .res (res.source)
  );

  stumpff_scoreboard stumpff_sb = new();

  // Idle percentages for each side; the hold counter forces a long stall.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up after far longer than the slowest legal run needs.
  initial begin
    #400_000_000;
    $display("stumpff_c_s_evaluator_core regression: fail");
    $finish;
  end

  initial begin
    arg.valid = 1'b0;
    arg.mode  = 1'b0;
    arg.z_arg = '0;
    res.ready = 1'b0;
  end

  // Result side: count down any hold, otherwise take results at random.
  always @(negedge clk) begin
    if (recv_hold_cycles != 0) begin
      res.ready = 1'b0;
      recv_hold_cycles--;
    end else begin
      res.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample both channels at the rising edge; each handshake is one transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (arg.valid && arg.ready) stumpff_sb.note_argument(arg.mode, arg.z_arg);
      if (res.valid && res.ready) stumpff_sb.check_result(res.func_value, res.saturated);
    end
  end

  // Offer one argument: idle at random first, then hold valid until accepted.
  task send_arg(logic mode, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      arg.valid = 1'b0;
      @(negedge clk);
    end
    arg.valid = 1'b1;
    arg.mode  = mode;
    arg.z_arg = z;
    @(posedge clk);
    while (!arg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly |z| < 1 so the run stays short; the rest spans the full range.
  task send_random_arg();
    logic [31:0] z;
    if ($urandom_range(99) < 75) begin
      z = {8'd0, 24'($urandom())};
      if ($urandom_range(1)) z = 32'd0 - z;
    end else begin
      z = $urandom();
    end
    send_arg(1'($urandom_range(1)), z);
  endtask

  initial begin
    logic [31:0] corner_args[$];
    corner_args = '{32'h0000_0000, 32'h0100_0000, 32'hFF00_0000, 32'h00FF_FFFF,
                    32'hFF00_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h277A_6B00, 32'h0277_0000, 32'hF000_0000};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: zero, the |z| = 1 boundary, extremes, a full and a quarter turn of r.
    foreach (corner_args[i]) begin
      send_arg(1'b0, corner_args[i]);
      send_arg(1'b1, corner_args[i]);
    end

    // Sender idles less than receiver, then the reverse, then no idling.
    send_idle_pct = 26;
    recv_idle_pct = 59;
    repeat (275) send_random_arg();
    send_idle_pct = 59;
    recv_idle_pct = 26;
    repeat (275) send_random_arg();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Hold the result side long enough for two closed-form items to finish,
    // so the block fills and stalls input.
    recv_hold_cycles = 20000;
    repeat (275) send_random_arg();
    arg.valid = 1'b0;

    while (stumpff_sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Checked %0d results: %0d series-branch, %0d closed-form, %0d saturated.",
             stumpff_sb.checked_count, stumpff_sb.series_count,
             stumpff_sb.closed_count, stumpff_sb.sat_count);
    if (stumpff_sb.error_count == 0) begin
      $display("stumpff_c_s_evaluator_core regression: pass");
    end else begin
      $display("Mismatches: %0d", stumpff_sb.error_count);
      $display("stumpff_c_s_evaluator_core regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
